// ===== src/bpet_pkg.sv =====
// Shared constants and register codes for the binary Prewitt edge threshold block.
package bpet_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	localparam int SIZE_W   = 11;
	localparam int THRESH_W = 5;
	localparam int ENERGY_W = 5;
	localparam int COORD_W  = 10;

	localparam logic [SIZE_W-1:0]   RST_WIDTH  = 11'd1024;
	localparam logic [SIZE_W-1:0]   RST_HEIGHT = 11'd1024;
	localparam logic [THRESH_W-1:0] RST_THRESH = 5'd8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_THRESH = 2'd2
	} bpet_reg_t;

endpackage

// ===== src/bpet_ifs.sv =====
// Handshake channel interfaces: pixel input, result output and register writes.
interface bpet_pix_if;
	logic valid;
	logic ready;
	logic pixel;

	modport source (output valid, output pixel, input ready);
	modport sink (input valid, input pixel, output ready);
endinterface

interface bpet_res_if;
	logic                         valid;
	logic                         ready;
	logic                         flat_bit;
	logic [bpet_pkg::ENERGY_W-1:0] energy;
	logic [bpet_pkg::COORD_W-1:0]  out_col;
	logic [bpet_pkg::COORD_W-1:0]  out_row;
	logic                         frame_last;

	modport source (output valid, output flat_bit, output energy, output out_col,
		output out_row, output frame_last, input ready);
	modport sink (input valid, input flat_bit, input energy, input out_col,
		input out_row, input frame_last, output ready);
endinterface

interface bpet_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [bpet_pkg::CFG_IDX_W-1:0]  index;
	logic [bpet_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/binary_prewitt_edge_threshold_core.sv =====
// Streaming 3x3 Prewitt edge threshold over a binary image, one pixel per request.
//
// Channels: pix carries one binary pixel per request in raster order. res carries one
// result per fully covered 3x3 window: flat_bit, energy (0 to 18), the window's top-left
// out_col/out_row, and frame_last on the final result of a frame. Pixels in the first
// two rows or the first two columns give no result. cfg.ready is always high; cfg writes
// image_width (index 0), image_height (index 1) and edge_threshold (index 2); a size write
// restarts the frame. The user writes registers only while idle; the block does not enforce it.
//
// Throughput is one pixel per cycle while res is not stalled: the line buffer is a single
// memory read at the accepted pixel's column, written back at that column when the pixel
// leaves the read stage, and the next pixel always lies in another column. An accepted
// pixel passes the read stage and then the result register, which drives res.valid and
// loads whenever it is empty or res.ready is high.
//
// Reset clears the counters, the window and the handshake state and loads the default
// sizes of 1024 x 1024 and a threshold of 8. The line buffer is not cleared; its entries
// are only used after they are written in the current frame. When res stalls, the result
// register holds and one more pixel can wait in the read stage; pix.ready drops then.
module binary_prewitt_edge_threshold_core #(
	parameter int MAX_WIDTH  = bpet_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bpet_pkg::DEF_MAX_HEIGHT
) (
	input  logic        clk,
	input  logic        arst_n,
	bpet_pix_if.sink    pix,
	bpet_res_if.source  res,
	bpet_cfg_if.sink    cfg
);
	import bpet_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);

	function automatic logic [CW-1:0] col_last(input logic [SIZE_W-1:0] v);
		logic [31:0] e;
		e = 32'(v);
		if (e < 32'd3) e = 32'd3;
		if (e > 32'(MAX_WIDTH)) e = 32'(MAX_WIDTH);
		return CW'(e - 32'd1);
	endfunction

	function automatic logic [RW-1:0] row_last(input logic [SIZE_W-1:0] v);
		logic [31:0] e;
		e = 32'(v);
		if (e < 32'd3) e = 32'd3;
		if (e > 32'(MAX_HEIGHT)) e = 32'(MAX_HEIGHT);
		return RW'(e - 32'd1);
	endfunction

	// Configuration and position state
	logic [CW-1:0]       col_q, col_last_q;
	logic [RW-1:0]       row_q, row_last_q;
	logic [THRESH_W-1:0] thresh_q;
	logic [5:0]          win_q;

	// Line buffer: bit 1 is the pixel two rows back, bit 0 one row back.
	logic [1:0] lb_mem [MAX_WIDTH];

	// Read stage
	logic          v_s1;
	logic          px_s1, emit_s1, last_s1;
	logic [CW-1:0] col_s1;
	logic [RW-1:0] row_s1;
	logic [1:0]    rd_s1;

	// Result register
	logic                out_v_q;
	logic                flat_q, frame_last_q;
	logic [ENERGY_W-1:0] energy_q;
	logic [COORD_W-1:0]  ocol_q, orow_q;

	logic accept_in, adv_out, s1_leave, cfg_wr;
	logic emit_in, last_in;
	logic [8:0] win;
	logic [1:0] top_s, bot_s, lft_s, rgt_s, a1, a2;
	logic [3:0] sq1, sq2;
	logic [ENERGY_W-1:0] energy;

	assign adv_out   = !out_v_q || res.ready;
	assign pix.ready = !v_s1 || adv_out;
	assign accept_in = pix.valid && pix.ready;
	assign s1_leave  = v_s1 && adv_out;
	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid && cfg.ready;

	assign emit_in = (col_q >= CW'(2)) && (row_q >= RW'(2));
	assign last_in = (col_q == col_last_q) && (row_q == row_last_q);

	// Window columns: bits 8..6 left, 5..3 middle, 2..0 right; top bit first in each.
	always_comb begin
		win   = {win_q, rd_s1[1], rd_s1[0], px_s1};
		top_s = 2'({1'b0, win[8]} + {1'b0, win[5]} + {1'b0, win[2]});
		bot_s = 2'({1'b0, win[6]} + {1'b0, win[3]} + {1'b0, win[0]});
		lft_s = 2'({1'b0, win[8]} + {1'b0, win[7]} + {1'b0, win[6]});
		rgt_s = 2'({1'b0, win[2]} + {1'b0, win[1]} + {1'b0, win[0]});
		a1    = (bot_s >= top_s) ? 2'(bot_s - top_s) : 2'(top_s - bot_s);
		a2    = (rgt_s >= lft_s) ? 2'(rgt_s - lft_s) : 2'(lft_s - rgt_s);
		sq1   = {2'b00, a1} * {2'b00, a1};
		sq2   = {2'b00, a2} * {2'b00, a2};
		energy = {1'b0, sq1} + {1'b0, sq2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			win_q      <= '0;
			col_last_q <= col_last(RST_WIDTH);
			row_last_q <= row_last(RST_HEIGHT);
			thresh_q   <= RST_THRESH;
		end else if (cfg_wr) begin
			unique case (cfg.index)
				REG_WIDTH: begin
					col_last_q <= col_last(cfg.data);
					col_q      <= '0;
					row_q      <= '0;
					win_q      <= '0;
				end
				REG_HEIGHT: begin
					row_last_q <= row_last(cfg.data);
					col_q      <= '0;
					row_q      <= '0;
					win_q      <= '0;
				end
				REG_THRESH: begin
					thresh_q <= cfg.data[THRESH_W-1:0];
				end
				default: begin
				end
			endcase
		end else begin
			if (accept_in) begin
				if (col_q == col_last_q) begin
					col_q <= '0;
					row_q <= (row_q == row_last_q) ? '0 : RW'(row_q + RW'(1));
				end else begin
					col_q <= CW'(col_q + CW'(1));
				end
			end
			if (s1_leave) begin
				win_q <= win[5:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (pix.ready) v_s1 <= accept_in;
			if (adv_out) out_v_q <= v_s1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			rd_s1   <= lb_mem[col_q];
			px_s1   <= pix.pixel;
			col_s1  <= col_q;
			row_s1  <= row_q;
			emit_s1 <= emit_in;
			last_s1 <= last_in;
		end
		if (s1_leave) begin
			lb_mem[col_s1] <= {rd_s1[0], px_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out) begin
			flat_q       <= energy < ENERGY_W'(thresh_q);
			energy_q     <= energy;
			ocol_q       <= COORD_W'(col_s1 - CW'(2));
			orow_q       <= COORD_W'(row_s1 - RW'(2));
			frame_last_q <= last_s1;
		end
	end

	assign res.valid      = out_v_q;
	assign res.flat_bit   = flat_q;
	assign res.energy     = energy_q;
	assign res.out_col    = ocol_q;
	assign res.out_row    = orow_q;
	assign res.frame_last = frame_last_q;

	// The position counters never run past the configured frame size.
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= col_last_q && row_q <= row_last_q)
		else $error("position counter beyond frame size");

	// A held read stage must block new pixels, or a line buffer write would be lost.
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !adv_out |-> !pix.ready)
		else $error("pixel accepted while read stage stalled");

	// The end-of-frame result sits at the last window column.
	a_last_col: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.frame_last |-> res.out_col == COORD_W'(col_last_q - CW'(2)))
		else $error("frame_last on wrong column");

	// Gradient energy can never exceed eighteen.
	a_energy_max: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> res.energy <= ENERGY_W'(18))
		else $error("energy out of range");

endmodule
